// ----- hdl/mfb_pkg.sv -----
// ----------------------------------------------------------------------------
// Monochrome frame buffer package
// Shared types, operation codes and the pixel mask function of the
// rectangle fill frame buffer.
// ----------------------------------------------------------------------------
package mfb_pkg;

   localparam int ROW_W  = 10;
   localparam int XPOS_W = 10;
   localparam int COL_W  = 7;
   localparam int BYTE_W = 8;
   localparam int PROD_W = ROW_W + COL_W;

   localparam logic [1:0] FUNC_FILL  = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [BYTE_W-1:0] BYTE_WHITE = 8'hFF;
   localparam logic [2:0]        BIT_LAST   = 3'h7;

   typedef struct packed {
      logic [1:0]        func;
      logic [XPOS_W-1:0] left_x;
      logic [ROW_W-1:0]  top_y;
      logic [XPOS_W-1:0] right_x;
      logic [ROW_W-1:0]  bottom_y;
      logic              pixel_color;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_column;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              read_valid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_CLEAR,
      ST_READ_ADDR,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   // Bits lo to hi inclusive set, bit 0 being the leftmost pixel.
   function automatic logic [BYTE_W-1:0] span_mask(input logic [2:0] lo,
                                                   input logic [2:0] hi);
      logic [BYTE_W-1:0] from_lo;
      logic [BYTE_W-1:0] to_hi;
      from_lo   = BYTE_WHITE << lo;
      to_hi     = BYTE_WHITE >> (BIT_LAST - hi);
      span_mask = from_lo & to_hi;
   endfunction

endpackage

// ----- hdl/mfb_store.sv -----
// ----------------------------------------------------------------------------
// Frame store
// Single-port byte memory holding the image, with registered read data.
// ----------------------------------------------------------------------------
module mfb_store #(
   parameter int DEPTH  = 12000,
   parameter int ADDR_W = 14
) (
   input  logic                      clock,
   input  logic                      mem_we,
   input  logic                      mem_re,
   input  logic [ADDR_W-1:0]         mem_addr,
   input  logic [mfb_pkg::BYTE_W-1:0] mem_wdata,
   output logic [mfb_pkg::BYTE_W-1:0] mem_rdata
);
   import mfb_pkg::*;

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ----- hdl/mfb_seq.sv -----
// ----------------------------------------------------------------------------
// Frame buffer sequencer
// Orders the box corners, then walks rows and byte columns through one
// shared address adder, doing a read-modify-write of each byte. Also runs
// the clear sweep, the byte read and the result register.
// ----------------------------------------------------------------------------
module mfb_seq #(
   parameter int LINES          = 240,
   parameter int BYTES_PER_LINE = 50,
   parameter int DEPTH          = 12000,
   parameter int ADDR_W         = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mfb_pkg::req_type           req,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mfb_pkg::rsp_type           rsp,
   output logic                       mem_we,
   output logic                       mem_re,
   output logic [ADDR_W-1:0]          mem_addr,
   output logic [mfb_pkg::BYTE_W-1:0] mem_wdata,
   input  logic [mfb_pkg::BYTE_W-1:0] mem_rdata
);
   import mfb_pkg::*;

   localparam logic [ROW_W:0]    LINES_X     = (ROW_W + 1)'(LINES);
   localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(LINES - 1);
   localparam logic [COL_W:0]    BPL_X       = (COL_W + 1)'(BYTES_PER_LINE);
   localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(BYTES_PER_LINE - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(BYTES_PER_LINE);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
   localparam logic [PROD_W-1:0] BPL_PROD    = PROD_W'(BYTES_PER_LINE);

   state_type         state_ff,      state_in;
   logic [1:0]        func_ff,       func_in;
   logic [XPOS_W-1:0] left_ff,       left_in;
   logic [XPOS_W-1:0] right_ff,      right_in;
   logic [ROW_W-1:0]  top_ff,        top_in;
   logic [ROW_W-1:0]  bottom_ff,     bottom_in;
   logic              color_ff,      color_in;
   logic [ROW_W-1:0]  rrow_ff,       rrow_in;
   logic [COL_W-1:0]  rcol_ff,       rcol_in;
   logic [COL_W-1:0]  first_col_ff,  first_col_in;
   logic [COL_W-1:0]  last_col_ff,   last_col_in;
   logic [ROW_W-1:0]  walk_row_ff,   walk_row_in;
   logic [COL_W-1:0]  walk_col_ff,   walk_col_in;
   logic [ADDR_W-1:0] base_ff,       base_in;
   rsp_type           res_ff,        res_in;
   rsp_type           rsp_ff,        rsp_in;
   logic              rsp_valid_ff,  rsp_valid_in;

   logic [ROW_W-1:0]  mul_row;
   logic [PROD_W-1:0] mul_prod;
   logic [COL_W-1:0]  add_col;
   logic [ADDR_W-1:0] add_sum;
   logic [COL_W-1:0]  right_col;
   logic [2:0]        lo_bit;
   logic [2:0]        hi_bit;
   logic [BYTE_W-1:0] mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_row_ff  <= '0;
         walk_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_row_ff  <= walk_row_in;
         walk_col_ff  <= walk_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      top_ff       <= top_in;
      bottom_ff    <= bottom_in;
      color_ff     <= color_in;
      rrow_ff      <= rrow_in;
      rcol_ff      <= rcol_in;
      first_col_ff <= first_col_in;
      last_col_ff  <= last_col_in;
      base_ff      <= base_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   // Shared address arithmetic: row base product and base plus column.
   assign mul_row  = (func_ff == FUNC_READ) ? rrow_ff : top_ff;
   assign mul_prod = PROD_W'(mul_row) * BPL_PROD;
   assign add_col  = (state_ff == ST_READ_ADDR) ? rcol_ff : walk_col_ff;
   assign add_sum  = base_ff + ADDR_W'(add_col);

   assign right_col = right_ff[XPOS_W-1:3];
   assign lo_bit    = (walk_col_ff == left_ff[XPOS_W-1:3]) ? left_ff[2:0] : 3'h0;
   assign hi_bit    = (walk_col_ff == right_col) ? right_ff[2:0] : BIT_LAST;
   assign mask      = span_mask(lo_bit, hi_bit);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      color_in     = color_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      first_col_in = first_col_ff;
      last_col_in  = last_col_ff;
      walk_row_in  = walk_row_ff;
      walk_col_in  = walk_col_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = add_sum;
      mem_wdata    = color_ff ? (mem_rdata | mask) : (mem_rdata & ~mask);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req.func;
               left_in   = (req.left_x < req.right_x) ? req.left_x : req.right_x;
               right_in  = (req.left_x < req.right_x) ? req.right_x : req.left_x;
               top_in    = (req.top_y < req.bottom_y) ? req.top_y : req.bottom_y;
               bottom_in = (req.top_y < req.bottom_y) ? req.bottom_y : req.top_y;
               color_in  = req.pixel_color;
               rrow_in   = req.read_row;
               rcol_in   = req.read_column;
               res_in    = '0;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            base_in      = mul_prod[ADDR_W-1:0];
            first_col_in = left_ff[XPOS_W-1:3];
            last_col_in  = ({1'b0, right_col} >= BPL_X) ? LAST_COL : right_col;
            state_in     = ST_DONE;
            case (func_ff)
               FUNC_FILL: begin
                  if (({1'b0, top_ff} < LINES_X) &&
                      ({1'b0, left_ff[XPOS_W-1:3]} < BPL_X)) begin
                     bottom_in   = ({1'b0, bottom_ff} >= LINES_X) ? LAST_ROW : bottom_ff;
                     walk_row_in = top_ff;
                     walk_col_in = left_ff[XPOS_W-1:3];
                     state_in    = ST_FILL_RD;
                  end
               end
               FUNC_CLEAR: begin
                  base_in  = '0;
                  state_in = ST_CLEAR;
               end
               FUNC_READ: begin
                  if (({1'b0, rrow_ff} < LINES_X) && ({1'b0, rcol_ff} < BPL_X)) begin
                     state_in = ST_READ_ADDR;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_FILL_RD: begin
            mem_re   = 1'b1;
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            mem_we   = 1'b1;
            state_in = ST_FILL_RD;
            if (walk_col_ff == last_col_ff) begin
               walk_col_in = first_col_ff;
               if (walk_row_ff == bottom_ff) begin
                  walk_row_in = '0;
                  walk_col_in = '0;
                  state_in    = ST_DONE;
               end else begin
                  walk_row_in = walk_row_ff + 1'b1;
                  base_in     = base_ff + ROW_STEP;
               end
            end else begin
               walk_col_in = walk_col_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = base_ff;
            mem_wdata = BYTE_WHITE;
            if (base_ff == LAST_ADDR) begin
               state_in = ST_DONE;
            end else begin
               base_in = base_ff + 1'b1;
            end
         end
         ST_READ_ADDR: begin
            mem_re   = 1'b1;
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            res_in.read_data  = mem_rdata;
            res_in.read_valid = 1'b1;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- hdl/mono_framebuffer_rect_fill_top.sv -----
// ----------------------------------------------------------------------------
// Monochrome frame buffer with rectangle fill
// One word at a time; each byte of a fill is a read then a write on the
// single store port. Reset returns control to idle; the store is not cleared.
// ----------------------------------------------------------------------------
module mono_framebuffer_rect_fill_top #(
   parameter int LINES          = 240,
   parameter int BYTES_PER_LINE = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mfb_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mfb_pkg::rsp_type rsp
);
   import mfb_pkg::*;

   localparam int DEPTH  = LINES * BYTES_PER_LINE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [BYTE_W-1:0] mem_wdata;
   logic [BYTE_W-1:0] mem_rdata;

   mfb_seq #(
      .LINES          (LINES),
      .BYTES_PER_LINE (BYTES_PER_LINE),
      .DEPTH          (DEPTH),
      .ADDR_W         (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   mfb_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

// ----- tb/sv/mono_framebuffer_rect_fill_top_tb.sv -----
// ----------------------------------------------------------------------------
// Monochrome frame buffer rectangle fill testbench
// Drives fill, clear, read and unused commands through the request channel
// and checks every response word against a byte-wide model of the frame
// store. Directed corner cases come first, then random traffic under
// several idle and stall mixes and one long response hold-off.
// ----------------------------------------------------------------------------
module mono_framebuffer_rect_fill_top_tb;
   import mfb_pkg::*;

   localparam int         LINES           = 240;
   localparam int         BYTES_PER_LINE  = 50;
   localparam int         STORE_BYTES     = LINES * BYTES_PER_LINE;
   localparam logic [1:0] FUNC_UNUSED     = 2'd3;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         DRAIN_CYCLES    = 20;
   localparam int         WATCHDOG_LIMIT  = 100000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   logic [BYTE_W-1:0] frame_model [STORE_BYTES];
   rsp_type           expected_answers [$];
   rsp_type           answer;
   int                error_count     = 0;
   int                gap_pct         = 0;
   int                stall_pct       = 0;
   int                hold_off_asked  = 0;
   int                hold_off_served = 0;
   int                hold_off_left   = 0;
   int                quiet_cycles    = 0;
   int                recent_row      = 0;
   int                recent_col      = 0;

   mono_framebuffer_rect_fill_top #(
      .LINES         (LINES),
      .BYTES_PER_LINE(BYTES_PER_LINE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type predict_answer(req_type w);
      rsp_type           a;
      int                lft, rgt, tp, bot, c_first, c_last, lo, hi, at;
      logic [BYTE_W-1:0] mask;
      a = '0;
      case (w.func)
         FUNC_FILL: begin
            lft     = (w.left_x < w.right_x) ? w.left_x : w.right_x;
            rgt     = (w.left_x < w.right_x) ? w.right_x : w.left_x;
            tp      = (w.top_y < w.bottom_y) ? w.top_y : w.bottom_y;
            bot     = (w.top_y < w.bottom_y) ? w.bottom_y : w.top_y;
            c_first = lft / 8;
            c_last  = rgt / 8;
            if (tp < LINES && c_first < BYTES_PER_LINE) begin
               if (bot >= LINES) bot = LINES - 1;
               if (c_last >= BYTES_PER_LINE) c_last = BYTES_PER_LINE - 1;
               for (int r = tp; r <= bot; r++) begin
                  for (int c = c_first; c <= c_last; c++) begin
                     lo   = (c == lft / 8) ? lft % 8 : 0;
                     hi   = (c == rgt / 8) ? rgt % 8 : 7;
                     mask = '0;
                     for (int b = lo; b <= hi; b++) mask[b] = 1'b1;
                     at = r * BYTES_PER_LINE + c;
                     if (w.pixel_color) frame_model[at] = frame_model[at] | mask;
                     else frame_model[at] = frame_model[at] & ~mask;
                  end
               end
            end
         end
         FUNC_CLEAR: begin
            foreach (frame_model[i]) frame_model[i] = BYTE_WHITE;
         end
         FUNC_READ: begin
            if (w.read_row < LINES && w.read_column < BYTES_PER_LINE) begin
               a.read_data  = frame_model[w.read_row * BYTES_PER_LINE + w.read_column];
               a.read_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   function automatic req_type command_word(logic [1:0] func, int ax, int ay, int bx, int by,
                                            logic color);
      req_type w;
      w             = '0;
      w.func        = func;
      w.left_x      = XPOS_W'(ax);
      w.top_y       = ROW_W'(ay);
      w.right_x     = XPOS_W'(bx);
      w.bottom_y    = ROW_W'(by);
      w.pixel_color = color;
      w.read_column = COL_W'(ax);
      w.read_row    = ROW_W'(ay);
      return w;
   endfunction

   // Most fills are small boxes placed anywhere, some past the store edges; reads mostly follow them.
   function automatic req_type random_word();
      req_type     w;
      logic [63:0] noise;
      int          pick, x0, y0, dx, dy;
      noise = {$urandom, $urandom};
      w     = noise[$bits(req_type)-1:0];
      pick  = $urandom_range(99);
      if (pick < 45) begin
         x0     = $urandom_range(8 * BYTES_PER_LINE + 15);
         y0     = $urandom_range(LINES + 5);
         dx     = $urandom_range(23);
         dy     = $urandom_range(11);
         w.func = FUNC_FILL;
         if ($urandom_range(1)) begin
            w.left_x  = XPOS_W'(x0 + dx);
            w.right_x = XPOS_W'(x0);
         end else begin
            w.left_x  = XPOS_W'(x0);
            w.right_x = XPOS_W'(x0 + dx);
         end
         if ($urandom_range(1)) begin
            w.top_y    = ROW_W'(y0 + dy);
            w.bottom_y = ROW_W'(y0);
         end else begin
            w.top_y    = ROW_W'(y0);
            w.bottom_y = ROW_W'(y0 + dy);
         end
         recent_row = y0;
         recent_col = x0 / 8;
      end else if (pick < 52) begin
         w.func = FUNC_FILL;
      end else if (pick < 90) begin
         w.func = FUNC_READ;
         if (pick < 80) begin
            w.read_row    = ROW_W'((recent_row + $urandom_range(11)) % LINES);
            w.read_column = COL_W'((recent_col + $urandom_range(3)) % BYTES_PER_LINE);
         end else if (pick < 85) begin
            w.read_row    = ROW_W'($urandom_range(LINES - 1));
            w.read_column = COL_W'($urandom_range(BYTES_PER_LINE - 1));
         end
      end else if (pick < 93) begin
         w.func = FUNC_CLEAR;
      end else begin
         w.func = FUNC_UNUSED;
      end
      return w;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
   endtask

   task automatic send_word(req_type w);
      req_valid <= 1'b1;
      req       <= w;
      do @(posedge clock); while (req_stall);
      expected_answers.push_back(predict_answer(w));
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_answers.size() != 0);
   endtask

   task automatic test_directed_cases();
      gap_pct   = 20;
      stall_pct = 20;
      send_word(command_word(FUNC_CLEAR, 0, 0, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, 0, 0, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, BYTES_PER_LINE - 1, LINES - 1, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, 0, LINES, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, BYTES_PER_LINE, 0, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, 127, 1023, 0, 0, 1'b0));
      send_word(command_word(FUNC_FILL, 1023, 1023, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, 25, 120, 0, 0, 1'b0));
      send_word(command_word(FUNC_FILL, 0, 0, 0, 0, 1'b1));
      send_word(command_word(FUNC_READ, 0, 0, 0, 0, 1'b0));
      send_word(command_word(FUNC_FILL, 13, 5, 10, 3, 1'b1));
      send_word(command_word(FUNC_READ, 1, 4, 0, 0, 1'b0));
      send_word(command_word(FUNC_FILL, 390, 235, 420, 250, 1'b1));
      send_word(command_word(FUNC_READ, BYTES_PER_LINE - 1, LINES - 1, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, 48, 235, 0, 0, 1'b0));
      send_word(command_word(FUNC_FILL, 0, LINES, 10, 300, 1'b1));
      send_word(command_word(FUNC_FILL, 8 * BYTES_PER_LINE, 0, 1023, 10, 1'b1));
      send_word(command_word(FUNC_UNUSED, 0, 0, 0, 0, 1'b1));
      send_word(command_word(FUNC_FILL, 7, 0, 8, 0, 1'b1));
      send_word(command_word(FUNC_READ, 0, 0, 0, 0, 1'b0));
      send_word(command_word(FUNC_READ, 1, 0, 0, 0, 1'b0));
      send_word(command_word(FUNC_CLEAR, 0, 0, 0, 0, 1'b0));
      send_word(command_word(FUNC_FILL, 5, 10, 3, 10, 1'b0));
      send_word(command_word(FUNC_READ, 0, 10, 0, 0, 1'b0));
      wait_for_answers();
   endtask

   task automatic test_random_traffic(int sender_idle, int receiver_stall, int count);
      gap_pct   = sender_idle;
      stall_pct = receiver_stall;
      repeat (count) send_word(random_word());
      wait_for_answers();
   endtask

   task automatic test_pressure();
      gap_pct   = 0;
      stall_pct = 0;
      hold_off_asked <= hold_off_asked + 1;
      repeat (12) send_word(random_word());
      wait_for_answers();
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_served != hold_off_asked) begin
         rsp_stall       <= 1'b1;
         hold_off_left   <= HOLD_OFF_CYCLES - 1;
         hold_off_served <= hold_off_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected response word", rsp, 0);
         end else begin
            answer = expected_answers.pop_front();
            if (rsp.read_data !== answer.read_data)
               report_mismatch("read_data", rsp.read_data, answer.read_data);
            if (rsp.read_valid !== answer.read_valid)
               report_mismatch("read_valid", rsp.read_valid, answer.read_valid);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("mono_framebuffer_rect_fill_top_tb: errors");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(0, 0, 16);
      test_pressure();
      test_random_traffic(45, 0, 16);
      test_random_traffic(0, 45, 16);
      test_random_traffic(38, 38, 16);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("mono_framebuffer_rect_fill_top_tb: clean");
      else
         $display("mono_framebuffer_rect_fill_top_tb: errors");
      $finish;
   end

endmodule

// ----- mono_framebuffer_rect_fill_top.f -----
hdl/mfb_pkg.sv
hdl/mfb_store.sv
hdl/mfb_seq.sv
hdl/mono_framebuffer_rect_fill_top.sv
tb/sv/mono_framebuffer_rect_fill_top_tb.sv
